[design/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define VRST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define VRST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/vrst_pkg.sv]
package vrst_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_LOCAL = 2'd1,
    SRC_VRAM  = 2'd2,
    SRC_OAM   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    VOP_NONE  = 2'd0,
    VOP_READ  = 2'd1,
    VOP_WRITE = 2'd2
  } vop_e;

  localparam logic [8:0]  DotLast     = 9'd340;
  localparam logic [8:0]  LineLast    = 9'd261;
  localparam logic [8:0]  VblankLine  = 9'd241;
  localparam logic [8:0]  PostLine    = 9'd240;
  localparam logic [8:0]  ClearDotEnd = 9'd64;
  localparam logic [14:0] StepRow     = 15'd32;
  localparam logic [14:0] StepCol     = 15'd1;
  localparam logic [7:0]  ByteOnes    = 8'hFF;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  read_source;
    logic        nmi_pulse;
    logic [1:0]  vram_op;
    logic [14:0] vram_addr;
    logic [7:0]  vram_wdata;
    logic [7:0]  oam_addr;
    logic        oam2_clear;
    logic [4:0]  oam2_index;
    logic [8:0]  scan_line_out;
    logic [8:0]  scan_dot_out;
  } res_t;

endpackage

[design/vrst_cmd_if.sv]
interface vrst_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output command, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_index, input write_data,
                output ready);
endinterface

[design/vrst_res_if.sv]
interface vrst_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  read_source;
  logic        nmi_pulse;
  logic [1:0]  vram_op;
  logic [14:0] vram_addr;
  logic [7:0]  vram_wdata;
  logic [7:0]  oam_addr;
  logic        oam2_clear;
  logic [4:0]  oam2_index;
  logic [8:0]  scan_line_out;
  logic [8:0]  scan_dot_out;

  modport source (output valid, output read_data, output read_source, output nmi_pulse,
                  output vram_op, output vram_addr, output vram_wdata, output oam_addr,
                  output oam2_clear, output oam2_index, output scan_line_out,
                  output scan_dot_out, input ready);
  modport sink (input valid, input read_data, input read_source, input nmi_pulse,
                input vram_op, input vram_addr, input vram_wdata, input oam_addr,
                input oam2_clear, input oam2_index, input scan_line_out,
                input scan_dot_out, output ready);
endinterface

[design/vrst_in_stage.sv]
module vrst_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  vrst_pkg::cmd_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output vrst_pkg::cmd_t item_o
);
  import vrst_pkg::*;

  logic valid_q, valid_d;
  cmd_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

[design/vrst_engine.sv]
`include "assert_macros.svh"

module vrst_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  vrst_pkg::cmd_t item_i,
  output vrst_pkg::res_t res_o
);
  import vrst_pkg::*;

  logic [8:0]  scan_line_q, scan_line_d;
  logic [8:0]  scan_dot_q, scan_dot_d;
  logic [7:0]  control_q, control_d;
  logic        vblank_q, vblank_d;
  logic [7:0]  sprite_addr_q, sprite_addr_d;
  logic [14:0] cur_addr_q, cur_addr_d;
  logic [14:0] tmp_addr_q, tmp_addr_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  bus_q, bus_d;

  logic        in_clear_window;
  logic [14:0] addr_step;
  logic [7:0]  wdata;

  // mask and fine x scroll have no visible effect in this block, so they are not kept

  assign in_clear_window = (scan_line_q < PostLine) && (scan_dot_q != 9'd0)
                           && (scan_dot_q <= ClearDotEnd);
  assign addr_step = control_q[2] ? StepRow : StepCol;
  assign wdata     = item_i.write_data;

  always_comb begin
    res_o               = '0;
    res_o.scan_line_out = scan_line_q;
    res_o.scan_dot_out  = scan_dot_q;
    scan_line_d   = scan_line_q;
    scan_dot_d    = scan_dot_q;
    control_d     = control_q;
    vblank_d      = vblank_q;
    sprite_addr_d = sprite_addr_q;
    cur_addr_d    = cur_addr_q;
    tmp_addr_d    = tmp_addr_q;
    toggle_d      = toggle_q;
    bus_d         = bus_q;

    unique case (item_i.command)
      CMD_TICK: begin
        if (scan_line_q == LineLast) begin
          if (scan_dot_q == 9'd1) begin
            vblank_d = 1'b0;
          end
        end else if (scan_line_q < PostLine) begin
          // odd dots of the first 64 clear one secondary sprite byte each
          if (in_clear_window && scan_dot_q[0]) begin
            res_o.oam2_clear = 1'b1;
            res_o.oam2_index = scan_dot_q[5:1];
          end
        end else if (scan_line_q == VblankLine && scan_dot_q == 9'd1) begin
          vblank_d        = 1'b1;
          res_o.nmi_pulse = control_q[7];
        end
        if (scan_dot_q == DotLast) begin
          scan_dot_d  = '0;
          scan_line_d = (scan_line_q == LineLast) ? 9'd0 : scan_line_q + 9'd1;
        end else begin
          scan_dot_d = scan_dot_q + 9'd1;
        end
      end
      CMD_READ: begin
        unique case (item_i.reg_index)
          REG_STATUS: begin
            // race: a read just before vblank sets sees the bit low
            res_o.read_data = {vblank_q && !(scan_line_q == VblankLine
                                             && scan_dot_q == 9'd0),
                               2'b00, bus_q[4:0]};
            res_o.read_source = SRC_LOCAL;
            vblank_d = 1'b0;
            toggle_d = 1'b0;
          end
          REG_OAM_DATA: begin
            if (in_clear_window) begin
              res_o.read_data   = ByteOnes;
              res_o.read_source = SRC_LOCAL;
            end else begin
              res_o.read_source = SRC_OAM;
              res_o.oam_addr    = sprite_addr_q;
            end
          end
          REG_DATA: begin
            res_o.read_source = SRC_VRAM;
            res_o.vram_op     = VOP_READ;
            res_o.vram_addr   = cur_addr_q;
            cur_addr_d        = cur_addr_q + addr_step;
          end
          default: begin
            res_o.read_data   = bus_q;
            res_o.read_source = SRC_LOCAL;
          end
        endcase
      end
      CMD_WRITE: begin
        bus_d = wdata;
        unique case (item_i.reg_index)
          REG_CTRL: begin
            control_d          = wdata;
            res_o.nmi_pulse    = !control_q[7] && wdata[7] && vblank_q;
            tmp_addr_d[11:10]  = wdata[1:0];
          end
          REG_OAM_ADDR: begin
            sprite_addr_d = wdata;
          end
          REG_SCROLL: begin
            if (!toggle_q) begin
              tmp_addr_d[4:0] = wdata[7:3];
            end else begin
              tmp_addr_d[9:5]   = wdata[7:3];
              tmp_addr_d[14:12] = wdata[2:0];
            end
            toggle_d = !toggle_q;
          end
          REG_ADDR: begin
            if (!toggle_q) begin
              tmp_addr_d = {1'b0, wdata[5:0], tmp_addr_q[7:0]};
            end else begin
              tmp_addr_d = {tmp_addr_q[14:8], wdata};
              cur_addr_d = {tmp_addr_q[14:8], wdata};
            end
            toggle_d = !toggle_q;
          end
          REG_DATA: begin
            res_o.vram_op    = VOP_WRITE;
            res_o.vram_addr  = cur_addr_q;
            res_o.vram_wdata = wdata;
            cur_addr_d       = cur_addr_q + addr_step;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_line_q   <= '0;
      scan_dot_q    <= '0;
      control_q     <= '0;
      vblank_q      <= 1'b0;
      sprite_addr_q <= '0;
      cur_addr_q    <= '0;
      tmp_addr_q    <= '0;
      toggle_q      <= 1'b0;
      bus_q         <= '0;
    end else if (fire_i) begin
      scan_line_q   <= scan_line_d;
      scan_dot_q    <= scan_dot_d;
      control_q     <= control_d;
      vblank_q      <= vblank_d;
      sprite_addr_q <= sprite_addr_d;
      cur_addr_q    <= cur_addr_d;
      tmp_addr_q    <= tmp_addr_d;
      toggle_q      <= toggle_d;
      bus_q         <= bus_d;
    end
  end

  `VRST_ASSERT(a_scan_range, scan_dot_q <= DotLast && scan_line_q <= LineLast, "scan position out of range")
  `VRST_ASSERT(a_dot_wrap, fire_i && item_i.command == CMD_TICK && scan_dot_q == DotLast |=> scan_dot_q == 9'd0, "dot counter did not wrap")
  `VRST_ASSERT(a_nmi_vblank, fire_i && res_o.nmi_pulse |=> vblank_q, "nmi raised outside vblank")
  `VRST_ASSERT(a_state_hold, !fire_i |=> $stable(cur_addr_q) && $stable(scan_dot_q), "state moved without a beat")
endmodule

[design/vrst_out_stage.sv]
`include "assert_macros.svh"

module vrst_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           take_o,
  input  vrst_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output vrst_pkg::res_t res_o
);
  import vrst_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign take_o  = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && take_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `VRST_ASSERT(a_vram_read_src, valid_q && res_q.read_source == SRC_VRAM |-> res_q.vram_op == VOP_READ, "vram read source without vram read")
  `VRST_ASSERT(a_clear_idx, valid_q && !res_q.oam2_clear |-> res_q.oam2_index == 5'd0, "clear index set without clear")
endmodule

[design/video_register_and_scan_timing.sv]
// pipeline: two register stages, the input register and then the result register
// throughput: one beat per cycle while res_o.ready holds, each beat yields exactly one result beat
// rate is set by the single state-update pass in vrst_engine, one item per clock unless res_o stalls
// reset: asynchronous active-low rst_ni clears scan position, engine state and valid flags to zero
module video_register_and_scan_timing (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrst_cmd_if.sink   cmd_i,
  vrst_res_if.source res_o
);
  import vrst_pkg::*;

  // input register: holds one command beat
  cmd_t in_item;
  cmd_t s1_item;
  logic s1_valid;
  logic take;
  logic fire;

  // engine output before the result register
  res_t eng_res;
  res_t out_res;

  assign in_item.command    = cmd_i.command;
  assign in_item.reg_index  = cmd_i.reg_index;
  assign in_item.write_data = cmd_i.write_data;

  vrst_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_i.valid),
    .ready_o (cmd_i.ready),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  // state advances only when the held beat moves into the result register
  assign fire = s1_valid && take;

  vrst_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item),
    .res_o  (eng_res)
  );

  // result register: takes a new beat only when empty or when its waiting result is taken
  vrst_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .take_o  (take),
    .res_i   (eng_res),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (out_res)
  );

  assign res_o.read_data     = out_res.read_data;
  assign res_o.read_source   = out_res.read_source;
  assign res_o.nmi_pulse     = out_res.nmi_pulse;
  assign res_o.vram_op       = out_res.vram_op;
  assign res_o.vram_addr     = out_res.vram_addr;
  assign res_o.vram_wdata    = out_res.vram_wdata;
  assign res_o.oam_addr      = out_res.oam_addr;
  assign res_o.oam2_clear    = out_res.oam2_clear;
  assign res_o.oam2_index    = out_res.oam2_index;
  assign res_o.scan_line_out = out_res.scan_line_out;
  assign res_o.scan_dot_out  = out_res.scan_dot_out;
endmodule

[tb/sv/tb_video_register_and_scan_timing.sv]
module tb_video_register_and_scan_timing;
  import vrst_pkg::*;

  // command code that the block must treat as a no-op
  localparam logic [1:0] CmdSpare = 2'd3;

  // raster geometry in plain integers for the stimulus position tracker
  localparam int LineDots  = int'(DotLast) + 1;
  localparam int FrameDots = LineDots * (int'(LineLast) + 1);

  // spots in the frame where random register traffic is concentrated
  localparam int NumSpots = 10;
  localparam int SpotLine [NumSpots] = '{0, 1, 63, 200, 239, 240, 241, 245, 260, 261};
  localparam int SpotDot  [NumSpots] = '{0, 40, 320, 100, 20, 335, 0, 150, 300, 0};
  localparam int SpotBeats[NumSpots] = '{90, 90, 90, 90, 90, 12, 110, 90, 90, 90};

  logic clk_i;
  logic rst_ni;

  vrst_cmd_if cmd_if ();
  vrst_res_if res_if ();

  video_register_and_scan_timing dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // one queued command beat plus the idle cycles the sender spends before it
  typedef struct {
    cmd_t beat;
    int   gap;
    bit   drain;   // hold the beat back until every result is back
  } bus_item_t;

  bus_item_t bus_items[$];
  res_t      due_results[$];

  // stimulus side: position the generator believes the raster is at
  int gen_line   = 0;
  int gen_dot    = 0;
  bit src_busy   = 1'b1;
  bit drain_next = 1'b0;

  // handshake bookkeeping
  bit cmd_taken    = 1'b0;
  bit res_taken    = 1'b0;
  int gap_left     = -1;
  int sink_wait    = 0;
  bit sink_busy    = 1'b0;
  int beats_queued = -1;
  int beats_taken  = 0;
  int res_seen     = 0;
  int errors       = 0;

  // predicted copy of the block's raster and register state
  logic [8:0]  beam_line = '0;
  logic [8:0]  beam_dot  = '0;
  logic [7:0]  ctrl_q    = '0;
  logic [7:0]  mask_q    = '0;
  logic        vblank_q  = 1'b0;
  logic [7:0]  oam_ptr_q = '0;
  logic [14:0] vaddr_q   = '0;
  logic [14:0] taddr_q   = '0;
  logic [2:0]  fine_x_q  = '0;
  logic        toggle_q  = 1'b0;
  logic [7:0]  bus_q     = '0;

  // works out the result beat of one command and advances the predicted state
  function automatic res_t advance_video(logic [1:0] c, logic [2:0] r, logic [7:0] d);
    res_t o;
    logic seen_vbl;
    o = '0;
    o.scan_line_out = beam_line;
    o.scan_dot_out  = beam_dot;
    case (c)
      CMD_TICK: begin
        if (beam_line == LineLast) begin
          // pre-render line: vblank drops at dot 1
          if (beam_dot == 9'd1) vblank_q = 1'b0;
        end else if (beam_line < PostLine) begin
          // visible lines: odd dots up to 63 wipe one secondary sprite byte
          if (beam_dot >= 9'd1 && beam_dot <= ClearDotEnd && beam_dot[0]) begin
            o.oam2_clear = 1'b1;
            o.oam2_index = 5'((beam_dot - 9'd1) >> 1);
          end
        end else if (beam_line == VblankLine && beam_dot == 9'd1) begin
          vblank_q = 1'b1;
          if (ctrl_q[7]) o.nmi_pulse = 1'b1;
        end
        if (beam_dot == DotLast) begin
          beam_dot = '0;
          if (beam_line == LineLast) beam_line = '0;
          else beam_line = beam_line + 9'd1;
        end else begin
          beam_dot = beam_dot + 9'd1;
        end
      end
      CMD_READ: begin
        case (r)
          REG_STATUS: begin
            // reading right before vblank sets hides the flag
            seen_vbl = vblank_q;
            if (beam_line == VblankLine && beam_dot == 9'd0) seen_vbl = 1'b0;
            o.read_data   = {seen_vbl, 2'b00, bus_q[4:0]};
            o.read_source = SRC_LOCAL;
            vblank_q = 1'b0;
            toggle_q = 1'b0;
          end
          REG_OAM_DATA: begin
            if (beam_line < PostLine && beam_dot >= 9'd1 && beam_dot <= ClearDotEnd) begin
              o.read_data   = ByteOnes;
              o.read_source = SRC_LOCAL;
            end else begin
              o.read_source = SRC_OAM;
              o.oam_addr    = oam_ptr_q;
            end
          end
          REG_DATA: begin
            o.read_source = SRC_VRAM;
            o.vram_op     = VOP_READ;
            o.vram_addr   = vaddr_q;
            vaddr_q = vaddr_q + (ctrl_q[2] ? StepRow : StepCol);
          end
          default: begin
            o.read_data   = bus_q;
            o.read_source = SRC_LOCAL;
          end
        endcase
      end
      CMD_WRITE: begin
        bus_q = d;
        case (r)
          REG_CTRL: begin
            if (!ctrl_q[7] && d[7] && vblank_q) o.nmi_pulse = 1'b1;
            ctrl_q = d;
            taddr_q[11:10] = d[1:0];
          end
          REG_MASK:     mask_q = d;
          REG_OAM_ADDR: oam_ptr_q = d;
          REG_SCROLL: begin
            if (!toggle_q) begin
              taddr_q[4:0] = d[7:3];
              fine_x_q = d[2:0];
            end else begin
              taddr_q[9:5]   = d[7:3];
              taddr_q[14:12] = d[2:0];
            end
            toggle_q = ~toggle_q;
          end
          REG_ADDR: begin
            if (!toggle_q) begin
              taddr_q = {1'b0, d[5:0], taddr_q[7:0]};
            end else begin
              taddr_q[7:0] = d;
              vaddr_q = taddr_q;
            end
            toggle_q = ~toggle_q;
          end
          REG_DATA: begin
            o.vram_op    = VOP_WRITE;
            o.vram_addr  = vaddr_q;
            o.vram_wdata = d;
            vaddr_q = vaddr_q + (ctrl_q[2] ? StepRow : StepCol);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return o;
  endfunction

  // queue one command beat and keep the generator's raster position in step
  task automatic put(int c, int r, int d, bit calm = 1'b0);
    bus_item_t it;
    it.beat.command    = 2'(c);
    it.beat.reg_index  = 3'(r);
    it.beat.write_data = 8'(d);
    it.gap   = (src_busy && !calm) ? int'($urandom_range(0, 11)) : 0;
    it.drain = drain_next;
    drain_next = 1'b0;
    bus_items.push_back(it);
    if (c == CMD_TICK) begin
      gen_dot++;
      if (gen_dot == LineDots) begin
        gen_dot = 0;
        gen_line++;
        if (gen_line > int'(LineLast)) gen_line = 0;
      end
    end
  endtask

  // back-to-back dot ticks with random junk in the unused fields
  task automatic run_ticks(int n);
    repeat (n) put(CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 255), 1'b1);
  endtask

  // one random piece of CPU traffic, mostly well-formed register sequences
  task automatic rand_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 8)) put(CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 255));
    end else if (pick < 45) begin
      // scroll pair, sometimes after a status read resets the toggle
      if ($urandom_range(0, 1)) put(CMD_READ, REG_STATUS, $urandom_range(0, 255));
      put(CMD_WRITE, REG_SCROLL, $urandom_range(0, 255));
      put(CMD_WRITE, REG_SCROLL, $urandom_range(0, 255));
    end else if (pick < 60) begin
      // address pair followed by a few data port accesses
      if ($urandom_range(0, 1)) put(CMD_READ, REG_STATUS, $urandom_range(0, 255));
      put(CMD_WRITE, REG_ADDR, $urandom_range(0, 255));
      put(CMD_WRITE, REG_ADDR, $urandom_range(0, 255));
      repeat ($urandom_range(1, 4))
        put($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, REG_DATA, $urandom_range(0, 255));
    end else if (pick < 70) begin
      put(CMD_WRITE, REG_CTRL, $urandom_range(0, 255));
    end else if (pick < 78) begin
      put(CMD_READ, REG_STATUS, $urandom_range(0, 255));
    end else if (pick < 86) begin
      put(CMD_WRITE, REG_OAM_ADDR, $urandom_range(0, 255));
      put(CMD_READ, REG_OAM_DATA, $urandom_range(0, 255));
    end else if (pick < 97) begin
      put($urandom_range(1, 2), $urandom_range(0, 7), $urandom_range(0, 255));
    end else begin
      put(CmdSpare, $urandom_range(0, 7), $urandom_range(0, 255));
    end
  endtask

  task automatic check_field(string what, logic [14:0] want, logic [14:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    end
  endtask

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #120000000;
    $display("== FAIL ==");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int here;
    int there;
    int stop;
    rst_ni               = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = CMD_TICK;
    cmd_if.reg_index     = REG_CTRL;
    cmd_if.write_data    = 8'h00;
    res_if.ready         = 1'b0;

    // directed: every register read and written from the reset position
    put(CMD_READ,  REG_CTRL,     8'h00);
    put(CMD_READ,  REG_OAM_DATA, 8'hFF);   // dot 0 is outside the wipe window
    put(CMD_WRITE, REG_CTRL,     8'h04);   // data port steps by a row
    put(CMD_WRITE, REG_MASK,     8'hFF);
    put(CMD_WRITE, REG_STATUS,   8'h5F);   // only the bus latch moves
    put(CMD_READ,  REG_STATUS,   8'h00);
    put(CMD_WRITE, REG_OAM_ADDR, 8'hFF);
    put(CMD_READ,  REG_OAM_DATA, 8'h00);
    put(CMD_WRITE, REG_OAM_DATA, 8'hA5);
    put(CMD_WRITE, REG_SCROLL,   8'hFF);
    put(CMD_WRITE, REG_SCROLL,   8'h00);
    put(CMD_WRITE, REG_ADDR,     8'hFF);
    put(CMD_WRITE, REG_ADDR,     8'hFF);
    put(CMD_WRITE, REG_DATA,     8'hFF);
    put(CMD_READ,  REG_DATA,     8'h00);
    put(CMD_WRITE, REG_CTRL,     8'h00);   // back to single steps
    put(CMD_READ,  REG_DATA,     8'h00);
    put(CMD_READ,  REG_SCROLL,   8'h00);
    put(CMD_READ,  REG_ADDR,     8'h00);
    put(CMD_READ,  REG_MASK,     8'h00);
    put(CMD_READ,  REG_OAM_ADDR, 8'h00);
    put(CMD_TICK,  REG_CTRL,     8'h00);
    put(CMD_READ,  REG_OAM_DATA, 8'h00);   // inside the wipe window now
    put(CmdSpare,  REG_DATA,     8'hFF);

    // random traffic at spots spread over two frames
    for (int fr = 0; fr < 2; fr++) begin
      if (fr > 0) run_ticks(FrameDots - (gen_line * LineDots + gen_dot));
      for (int s = 0; s < NumSpots; s++) begin
        here  = gen_line * LineDots + gen_dot;
        there = SpotLine[s] * LineDots + SpotDot[s];
        if (there > here) run_ticks(there - here);
        if (fr == 0 && SpotLine[s] == int'(VblankLine)) begin
          // directed: status race, vblank entry and the control nmi edge
          src_busy = 1'b1;
          put(CMD_WRITE, REG_CTRL,   8'h80);
          put(CMD_READ,  REG_STATUS, 8'h00);   // one dot before vblank
          put(CMD_TICK,  REG_CTRL,   8'h00);
          put(CMD_TICK,  REG_CTRL,   8'h00);   // vblank sets, nmi fires
          put(CMD_WRITE, REG_CTRL,   8'h00);
          put(CMD_WRITE, REG_CTRL,   8'h80);   // rising bit 7 inside vblank
          put(CMD_WRITE, REG_CTRL,   8'h80);   // no edge this time
          put(CMD_READ,  REG_STATUS, 8'h00);
          put(CMD_READ,  REG_STATUS, 8'h00);
          put(CMD_WRITE, REG_CTRL,   8'h00);
          put(CMD_WRITE, REG_CTRL,   8'h80);   // vblank already cleared
        end
        src_busy   = ($urandom_range(0, 2) != 0);
        drain_next = (s == 3) || ($urandom_range(0, 5) == 0);
        stop = bus_items.size() + SpotBeats[s];
        while (bus_items.size() < stop) rand_step();
      end
    end
    beats_queued = bus_items.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all beats in, all results back, then a little settling time
    wait (beats_taken == beats_queued);
    wait (due_results.size() == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // driver: presents queued beats at the falling edge, honoring gaps and drains
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (bus_items.size() == 0) begin
        cmd_if.valid <= 1'b0;
      end else begin
        if (gap_left < 0) gap_left = bus_items[0].gap;
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (bus_items[0].drain && due_results.size() != 0) begin
          // let the pipeline empty before this beat
          cmd_if.valid <= 1'b0;
        end else begin
          cmd_if.command    <= bus_items[0].beat.command;
          cmd_if.reg_index  <= bus_items[0].beat.reg_index;
          cmd_if.write_data <= bus_items[0].beat.write_data;
          cmd_if.valid      <= 1'b1;
          void'(bus_items.pop_front());
          gap_left = -1;
        end
      end
    end
  end

  // result side back-pressure: quiet stretches and busy stretches of stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        if (res_seen % 128 == 0) sink_busy = ($urandom_range(0, 3) == 0);
        sink_wait = sink_busy ? int'($urandom_range(0, 11)) : 0;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on each accepted command beat, checks each result beat
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    cmd_taken <= cmd_if.valid && cmd_if.ready;
    res_taken <= res_if.valid && res_if.ready;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        due_results.push_back(advance_video(cmd_if.command, cmd_if.reg_index,
                                            cmd_if.write_data));
        beats_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        res_seen++;
        got = '{read_data:     res_if.read_data,
                read_source:   res_if.read_source,
                nmi_pulse:     res_if.nmi_pulse,
                vram_op:       res_if.vram_op,
                vram_addr:     res_if.vram_addr,
                vram_wdata:    res_if.vram_wdata,
                oam_addr:      res_if.oam_addr,
                oam2_clear:    res_if.oam2_clear,
                oam2_index:    res_if.oam2_index,
                scan_line_out: res_if.scan_line_out,
                scan_dot_out:  res_if.scan_dot_out};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got 0x%0h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("read_data",     15'(want.read_data),     15'(got.read_data));
          check_field("read_source",   15'(want.read_source),   15'(got.read_source));
          check_field("nmi_pulse",     15'(want.nmi_pulse),     15'(got.nmi_pulse));
          check_field("vram_op",       15'(want.vram_op),       15'(got.vram_op));
          check_field("vram_addr",     want.vram_addr,          got.vram_addr);
          check_field("vram_wdata",    15'(want.vram_wdata),    15'(got.vram_wdata));
          check_field("oam_addr",      15'(want.oam_addr),      15'(got.oam_addr));
          check_field("oam2_clear",    15'(want.oam2_clear),    15'(got.oam2_clear));
          check_field("oam2_index",    15'(want.oam2_index),    15'(got.oam2_index));
          check_field("scan_line_out", 15'(want.scan_line_out), 15'(got.scan_line_out));
          check_field("scan_dot_out",  15'(want.scan_dot_out),  15'(got.scan_dot_out));
        end
      end
    end
  end

endmodule

[filelist.f]
+incdir+design
design/vrst_pkg.sv
design/vrst_cmd_if.sv
design/vrst_res_if.sv
design/vrst_in_stage.sv
design/vrst_engine.sv
design/vrst_out_stage.sv
design/video_register_and_scan_timing.sv
tb/sv/tb_video_register_and_scan_timing.sv
